@@ design/ffu_pkg.sv @@
// Shared types, constants and helper functions for the flipbook frame UV block.
// No dependencies; every other design file takes names from here by scope.
`default_nettype none

package ffu_pkg;

   // Sheet and fixed-point limits
   localparam int MAX_FRAMES_PER_AXIS = 256;
   localparam int FRACTION_BITS       = 16;

   // Field widths fixed by the interface
   localparam int LIFE_W      = 32;
   localparam int PHASE_W     = 16;
   localparam int UV_W        = 16;
   localparam int CORNER_W    = 24;
   localparam int CSR_AXIS_W  = 9;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   // Derived internal widths
   localparam int AXIS_W   = $clog2(MAX_FRAMES_PER_AXIS + 1);  // holds 1..MAX
   localparam int CELL_W   = $clog2(MAX_FRAMES_PER_AXIS);      // holds 0..MAX-1
   localparam int TOTAL_W  = 2 * AXIS_W;                       // across * down
   localparam int T_W      = FRACTION_BITS + 1;                // Q1.FRACTION_BITS
   localparam int CPROD_W  = CELL_W + UV_W + 1;                // corner sum width

   // Pipeline depth from accepted beat to result strobe
   localparam int LATENCY = FRACTION_BITS + CELL_W + 7;

   localparam logic [LIFE_W-1:0]   LIFE_FLOOR = LIFE_W'(7);
   localparam logic [T_W-1:0]      T_ONE      = {1'b1, {FRACTION_BITS{1'b0}}};
   localparam logic [CORNER_W-1:0] CORNER_MAX = '1;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_MODE            = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FRAMES_ACROSS   = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_FRAMES_DOWN     = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH_UV  = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT_UV = CSR_INDEX_W'(4);

   typedef struct packed {
      logic [LIFE_W-1:0]  lifetime;
      logic [LIFE_W-1:0]  age;
      logic [PHASE_W-1:0] random_phase;
      logic               last_particle;
   } req_type;

   typedef struct packed {
      logic [CORNER_W-1:0] u_left;
      logic [CORNER_W-1:0] v_top;
      logic [CORNER_W-1:0] u_right;
      logic [CORNER_W-1:0] v_bottom;
      logic                last_result;
   } rsp_type;

   // Effective sheet setup, derived from the raw registers
   typedef struct packed {
      logic               mode;
      logic [AXIS_W-1:0]  across;
      logic [TOTAL_W-1:0] total;
      logic [UV_W-1:0]    frame_w;
      logic [UV_W-1:0]    frame_h;
   } cfg_type;

   // Normalized time beat, time stage to frame select
   typedef struct packed {
      logic           valid;
      logic           last;
      logic [T_W-1:0] t;
   } time_beat_type;

   // Frame cell beat, frame select to corner stage
   typedef struct packed {
      logic              valid;
      logic              last;
      logic [CELL_W-1:0] col;
      logic [CELL_W-1:0] row;
   } cell_beat_type;

   // Clamp a raw axis count to 1..MAX_FRAMES_PER_AXIS
   function automatic logic [AXIS_W-1:0] axis_count(logic [CSR_AXIS_W-1:0] v);
      logic [AXIS_W-1:0] res;
      if (v == '0) begin
         res = AXIS_W'(1);
      end else if (32'(v) > 32'(MAX_FRAMES_PER_AXIS)) begin
         res = AXIS_W'(MAX_FRAMES_PER_AXIS);
      end else begin
         res = AXIS_W'(v);
      end
      return res;
   endfunction

   // Rescale a Q0.16 phase to Q0.FRACTION_BITS, rounding down
   function automatic logic [FRACTION_BITS-1:0] phase_to_frac(logic [PHASE_W-1:0] p);
      logic [FRACTION_BITS+PHASE_W-1:0] w;
      w = {p, {FRACTION_BITS{1'b0}}};
      return w[FRACTION_BITS+PHASE_W-1:PHASE_W];
   endfunction

   // Saturate a corner value to the Q8.16 output range
   function automatic logic [CORNER_W-1:0] sat_corner(logic [CPROD_W-1:0] c);
      logic [CORNER_W-1:0] res;
      if (64'(c) > 64'(CORNER_MAX)) begin
         res = CORNER_MAX;
      end else begin
         res = CORNER_W'(c);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ design/ffu_norm_time.sv @@
// Normalized particle time: pipelined age/lifetime divider, clamp and phase wrap.
// Depends on ffu_pkg for widths, beat types and the phase rescale helper.
`default_nettype none

module ffu_norm_time (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  ffu_pkg::req_type       in_data,
   input  logic                   mode,
   output ffu_pkg::time_beat_type out_beat
);

   localparam int F    = ffu_pkg::FRACTION_BITS;
   localparam int T_W  = ffu_pkg::T_W;
   localparam int L_W  = ffu_pkg::LIFE_W;
   localparam int R_W  = L_W + 1;
   // Stage 0 is the input register, stages 1..T_W each retire one quotient bit
   localparam int NS   = T_W;

   logic           vld_ff  [0:NS];
   logic           vld_in  [0:NS];
   logic           last_ff [0:NS];
   logic           last_in [0:NS];
   logic           sat_ff  [0:NS];
   logic           sat_in  [0:NS];
   logic [F-1:0]   ph_ff   [0:NS];
   logic [F-1:0]   ph_in   [0:NS];
   logic [R_W-1:0] rem_ff  [0:NS];
   logic [R_W-1:0] rem_in  [0:NS];
   logic [L_W-1:0] div_ff  [0:NS];
   logic [L_W-1:0] div_in  [0:NS];
   logic [T_W-1:0] quo_ff  [0:NS];
   logic [T_W-1:0] quo_in  [0:NS];

   logic [L_W-1:0] life_floor;
   logic [T_W-1:0] t_div;
   logic [T_W-1:0] t_sum;
   logic [T_W-1:0] t_in;
   logic           out_vld_ff;
   logic           out_last_ff;
   logic [T_W-1:0] out_t_ff;

   // Floor lifetime; flag quotients of 2.0 or more up front
   assign life_floor = (in_data.lifetime < ffu_pkg::LIFE_FLOOR) ?
                       ffu_pkg::LIFE_FLOOR : in_data.lifetime;
   assign vld_in[0]  = in_valid;
   assign last_in[0] = in_data.last_particle;
   assign sat_in[0]  = {1'b0, in_data.age} >= {life_floor, 1'b0};
   assign ph_in[0]   = ffu_pkg::phase_to_frac(in_data.random_phase);
   assign rem_in[0]  = {1'b0, in_data.age};
   assign div_in[0]  = life_floor;
   assign quo_in[0]  = '0;

   // One restoring step per stage, most significant quotient bit first
   for (genvar j = 1; j <= NS; j++) begin : g_step
      logic [R_W-1:0] trial;
      logic [R_W-1:0] dext;
      logic           take;

      if (j == 1) begin : g_first
         assign trial = rem_ff[j-1];
      end else begin : g_next
         assign trial = {rem_ff[j-1][R_W-2:0], 1'b0};
      end

      assign dext       = {1'b0, div_ff[j-1]};
      assign take       = trial >= dext;
      assign rem_in[j]  = take ? (trial - dext) : trial;
      assign quo_in[j]  = T_W'({quo_ff[j-1], take});
      assign div_in[j]  = div_ff[j-1];
      assign vld_in[j]  = vld_ff[j-1];
      assign last_in[j] = last_ff[j-1];
      assign sat_in[j]  = sat_ff[j-1];
      assign ph_in[j]   = ph_ff[j-1];
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      for (int s = 0; s <= NS; s++) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_in[s];
         end
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      for (int s = 0; s <= NS; s++) begin
         last_ff[s] <= last_in[s];
         sat_ff[s]  <= sat_in[s];
         ph_ff[s]   <= ph_in[s];
         rem_ff[s]  <= rem_in[s];
         div_ff[s]  <= div_in[s];
         quo_ff[s]  <= quo_in[s];
      end
   end

   // Clamp to 1.0, then add phase and wrap below 1.0 in random mode
   assign t_div = (sat_ff[NS] || (quo_ff[NS] > ffu_pkg::T_ONE)) ?
                  ffu_pkg::T_ONE : quo_ff[NS];
   assign t_sum = t_div + {1'b0, ph_ff[NS]};

   always_comb begin
      t_in = t_div;
      if (mode) begin
         t_in = (t_sum >= ffu_pkg::T_ONE) ? (t_sum - ffu_pkg::T_ONE) : t_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      out_last_ff <= last_ff[NS];
      out_t_ff    <= t_in;
   end

   assign out_beat.valid = out_vld_ff;
   assign out_beat.last  = out_last_ff;
   assign out_beat.t     = out_t_ff;

endmodule

`default_nettype wire

@@ design/ffu_frame_sel.sv @@
// Frame select: time times frame count, end-of-life clamp, pipelined row/column divider.
// Depends on ffu_pkg for widths and the time and cell beat types.
`default_nettype none

module ffu_frame_sel (
   input  logic                           clock,
   input  logic                           reset,
   input  ffu_pkg::time_beat_type         in_beat,
   input  logic [ffu_pkg::AXIS_W-1:0]     across,
   input  logic [ffu_pkg::TOTAL_W-1:0]    total,
   output ffu_pkg::cell_beat_type         out_beat
);

   localparam int F      = ffu_pkg::FRACTION_BITS;
   localparam int T_W    = ffu_pkg::T_W;
   localparam int TOT_W  = ffu_pkg::TOTAL_W;
   localparam int CELL_W = ffu_pkg::CELL_W;
   localparam int PROD_W = T_W + TOT_W;
   localparam int RAW_W  = PROD_W - F;
   localparam int CMP_W  = TOT_W + ffu_pkg::AXIS_W;

   logic [PROD_W-1:0] prod;
   logic              mul_vld_ff;
   logic              mul_last_ff;
   logic [RAW_W-1:0]  raw_ff;
   logic [RAW_W-1:0]  raw_in;

   // Divider pipe: entry 0 holds the clamped index, entry s one quotient bit more
   logic              vld_ff  [0:CELL_W];
   logic              vld_in  [0:CELL_W];
   logic              last_ff [0:CELL_W];
   logic              last_in [0:CELL_W];
   logic [TOT_W-1:0]  rem_ff  [0:CELL_W];
   logic [TOT_W-1:0]  rem_in  [0:CELL_W];
   logic [CELL_W-1:0] quo_ff  [0:CELL_W];
   logic [CELL_W-1:0] quo_in  [0:CELL_W];

   // Scale time by the frame count
   assign prod   = PROD_W'(in_beat.t) * PROD_W'(total);
   assign raw_in = prod[PROD_W-1:F];

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= in_beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      mul_last_ff <= in_beat.last;
      raw_ff      <= raw_in;
   end

   // Hold the last frame at end of life
   assign vld_in[0]  = mul_vld_ff;
   assign last_in[0] = mul_last_ff;
   assign rem_in[0]  = (raw_ff >= RAW_W'(total)) ? (total - TOT_W'(1)) : TOT_W'(raw_ff);
   assign quo_in[0]  = '0;

   // Index div across: one shifted-divisor compare per stage
   for (genvar s = 1; s <= CELL_W; s++) begin : g_step
      localparam int K = CELL_W - s;
      logic [CMP_W-1:0] dsh;
      logic [CMP_W-1:0] rext;
      logic             take;

      assign dsh        = CMP_W'(across) << K;
      assign rext       = CMP_W'(rem_ff[s-1]);
      assign take       = rext >= dsh;
      assign rem_in[s]  = take ? TOT_W'(rext - dsh) : rem_ff[s-1];
      assign quo_in[s]  = CELL_W'({quo_ff[s-1], take});
      assign vld_in[s]  = vld_ff[s-1];
      assign last_in[s] = last_ff[s-1];
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= CELL_W; s++) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= CELL_W; s++) begin
         last_ff[s] <= last_in[s];
         rem_ff[s]  <= rem_in[s];
         quo_ff[s]  <= quo_in[s];
      end
   end

   // Remainder is the column, quotient the row
   assign out_beat.valid = vld_ff[CELL_W];
   assign out_beat.last  = last_ff[CELL_W];
   assign out_beat.col   = rem_ff[CELL_W][CELL_W-1:0];
   assign out_beat.row   = quo_ff[CELL_W];

endmodule

`default_nettype wire

@@ design/ffu_corner.sv @@
// Corner stage: cell position times frame size, far edge, saturation to Q8.16.
// Depends on ffu_pkg for widths, the cell beat type and the result payload.
`default_nettype none

module ffu_corner (
   input  logic                        clock,
   input  logic                        reset,
   input  ffu_pkg::cell_beat_type      in_beat,
   input  logic [ffu_pkg::UV_W-1:0]    frame_w,
   input  logic [ffu_pkg::UV_W-1:0]    frame_h,
   output logic                        out_valid,
   output ffu_pkg::rsp_type            out_data
);

   localparam int CELL_W  = ffu_pkg::CELL_W;
   localparam int UV_W    = ffu_pkg::UV_W;
   localparam int CPROD_W = ffu_pkg::CPROD_W;
   localparam int MUL_W   = CELL_W + UV_W;

   logic                 mul_vld_ff;
   logic                 mul_last_ff;
   logic [MUL_W-1:0]     cu_ff;
   logic [MUL_W-1:0]     cu_in;
   logic [MUL_W-1:0]     cv_ff;
   logic [MUL_W-1:0]     cv_in;
   logic [CPROD_W-1:0]   u_far;
   logic [CPROD_W-1:0]   v_far;
   logic                 rsp_vld_ff;
   ffu_pkg::rsp_type     rsp_ff;
   ffu_pkg::rsp_type     rsp_in;

   // Near corners
   assign cu_in = MUL_W'(in_beat.col) * MUL_W'(frame_w);
   assign cv_in = MUL_W'(in_beat.row) * MUL_W'(frame_h);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= in_beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      mul_last_ff <= in_beat.last;
      cu_ff       <= cu_in;
      cv_ff       <= cv_in;
   end

   // Far corners are one frame size on; saturate all four
   assign u_far = CPROD_W'(cu_ff) + CPROD_W'(frame_w);
   assign v_far = CPROD_W'(cv_ff) + CPROD_W'(frame_h);

   assign rsp_in.u_left      = ffu_pkg::sat_corner(CPROD_W'(cu_ff));
   assign rsp_in.v_top       = ffu_pkg::sat_corner(CPROD_W'(cv_ff));
   assign rsp_in.u_right     = ffu_pkg::sat_corner(u_far);
   assign rsp_in.v_bottom    = ffu_pkg::sat_corner(v_far);
   assign rsp_in.last_result = mul_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = rsp_vld_ff;
   assign out_data  = rsp_ff;

endmodule

`default_nettype wire

@@ design/flipbook_frame_uv_top.sv @@
// Top level of the flipbook frame UV block: configuration registers and the pipeline.
// Depends on ffu_pkg, ffu_norm_time, ffu_frame_sel and ffu_corner.
`default_nettype none

// The block takes one particle beat in every clock cycle in which busy is low and returns
// the texture rectangle of its sprite-sheet frame, one result beat per particle, in
// order. Most pipeline stages lie in the two dividers: the age/lifetime divider retires
// one quotient bit per stage (FRACTION_BITS + 1 stages) and the row/column divider one
// row bit per stage. Results appear on rsp_valid for a single cycle and cannot be held
// off; busy is high only while reset is applied. Write the registers only while no
// particle is in flight.
module flipbook_frame_uv_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  ffu_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   output ffu_pkg::rsp_type                 rsp_data,
   input  logic                             csr_write,
   input  logic [ffu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ffu_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int AXIS_W = ffu_pkg::AXIS_W;
   localparam int CSR_AW = ffu_pkg::CSR_AXIS_W;
   localparam int UV_W   = ffu_pkg::UV_W;

   logic                  mode_ff;
   logic [CSR_AW-1:0]     across_ff;
   logic [CSR_AW-1:0]     down_ff;
   logic [UV_W-1:0]       width_ff;
   logic [UV_W-1:0]       height_ff;

   logic [AXIS_W-1:0]     across_eff;
   logic [AXIS_W-1:0]     down_eff;
   ffu_pkg::cfg_type      cfg_ff;
   ffu_pkg::cfg_type      cfg_in;

   logic                  accept;
   ffu_pkg::time_beat_type time_beat;
   ffu_pkg::cell_beat_type cell_beat;

   assign busy   = reset;
   assign accept = start && !busy;

   // Configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         across_ff <= CSR_AW'(1);
         down_ff   <= CSR_AW'(1);
         width_ff  <= '1;
         height_ff <= '1;
      end else if (csr_write) begin
         case (csr_index)
            ffu_pkg::REG_MODE:            mode_ff   <= csr_data[0];
            ffu_pkg::REG_FRAMES_ACROSS:   across_ff <= csr_data[CSR_AW-1:0];
            ffu_pkg::REG_FRAMES_DOWN:     down_ff   <= csr_data[CSR_AW-1:0];
            ffu_pkg::REG_FRAME_WIDTH_UV:  width_ff  <= csr_data;
            ffu_pkg::REG_FRAME_HEIGHT_UV: height_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Derive effective sheet setup from the raw registers and register it
   assign across_eff     = ffu_pkg::axis_count(across_ff);
   assign down_eff       = ffu_pkg::axis_count(down_ff);
   assign cfg_in.mode    = mode_ff;
   assign cfg_in.across  = across_eff;
   assign cfg_in.total   = ffu_pkg::TOTAL_W'(across_eff) * ffu_pkg::TOTAL_W'(down_eff);
   assign cfg_in.frame_w = width_ff;
   assign cfg_in.frame_h = height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode    <= 1'b0;
         cfg_ff.across  <= AXIS_W'(1);
         cfg_ff.total   <= ffu_pkg::TOTAL_W'(1);
         cfg_ff.frame_w <= '1;
         cfg_ff.frame_h <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ffu_norm_time u_norm_time (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_data  (req_data),
      .mode     (cfg_ff.mode),
      .out_beat (time_beat)
   );

   ffu_frame_sel u_frame_sel (
      .clock    (clock),
      .reset    (reset),
      .in_beat  (time_beat),
      .across   (cfg_ff.across),
      .total    (cfg_ff.total),
      .out_beat (cell_beat)
   );

   ffu_corner u_corner (
      .clock     (clock),
      .reset     (reset),
      .in_beat   (cell_beat),
      .frame_w   (cfg_ff.frame_w),
      .frame_h   (cfg_ff.frame_h),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   // Normalized time never exceeds 1.0 after clamp and wrap
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      time_beat.valid |-> (time_beat.t <= ffu_pkg::T_ONE))
      else $error("normalized time above 1.0");

   // Frame cell lies inside the sheet
   a_cell_range: assert property (@(posedge clock) disable iff (reset)
      cell_beat.valid |-> ((32'(cell_beat.col) < 32'(across_eff)) &&
                           (32'(cell_beat.row) < 32'(down_eff))))
      else $error("frame cell outside the sheet");

   // Far corners never fall before near corners
   a_u_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.u_right >= rsp_data.u_left))
      else $error("u_right below u_left");

   a_v_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.v_bottom >= rsp_data.v_top))
      else $error("v_bottom below v_top");

endmodule

`default_nettype wire
